// ===== rtl/fcca_pkg.sv =====
package fcca_pkg;

	localparam int TABLE_ENTRIES = 4096;
	localparam int CLUSTER_BYTES = 512;

	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES);
	localparam int CLUSTER_SHIFT = $clog2(CLUSTER_BYTES);
	localparam int SIZE_W        = 21;
	localparam int SUM_W         = SIZE_W + 1;
	localparam int NEED_W        = SUM_W - CLUSTER_SHIFT;
	localparam int LINK_W        = 16;
	localparam int CLUSTER_W     = 12;
	localparam int OP_W          = 2;

	localparam logic [LINK_W-1:0] LINK_FREE = 16'h0000;
	localparam logic [LINK_W-1:0] LINK_END  = 16'hFFFF;

	localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(TABLE_ENTRIES - 1);

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_READ  = 2'd2,
		OP_LOAD  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ALLOC_CHK,
		ST_ALLOC_SCAN,
		ST_ALLOC_END,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_READ_WAIT,
		ST_LOAD_WR,
		ST_RESP
	} state_t;

endpackage

// ===== rtl/fcca_ram.sv =====
module fcca_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/fat_cluster_chain_allocator.sv =====
// Cluster chain allocator over a 4096 x 16 link table held in a single RAM.
// Read passes ST_READ_WAIT, load ST_LOAD_WR; free loops ST_FREE_WR, ST_FREE_RD per entry, or
// answers at once when the start is 0. Allocate answers from ST_ALLOC_CHK when short of
// space, else runs ST_ALLOC_SCAN and ST_ALLOC_END. One beat in flight; the next is taken in
// the cycle after the result loads. After arst_n the table is zeroed, in_stall held high.
module fat_cluster_chain_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [20:0] byte_size,
	input  logic [11:0] cluster_index,
	input  logic [15:0] entry_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [11:0] head_cluster,
	output logic [15:0] link_value
);

	fcca_pkg::state_t state_q, state_d;

	logic [fcca_pkg::IDX_W-1:0]     addr_q;
	logic [fcca_pkg::IDX_W-1:0]     hit_s1;
	logic                           pend_s1;
	logic [fcca_pkg::IDX_W-1:0]     prev_q;
	logic [fcca_pkg::NEED_W-1:0]    taken_q;
	logic [fcca_pkg::NEED_W-1:0]    need_q;
	logic [fcca_pkg::CNT_W-1:0]     free_cnt_q;
	logic [fcca_pkg::LINK_W-1:0]    val_q;
	logic                           res_status_q;
	logic [fcca_pkg::CLUSTER_W-1:0] res_first_q;
	logic [fcca_pkg::LINK_W-1:0]    res_link_q;
	logic                           out_valid_q;
	logic                           status_q;
	logic [fcca_pkg::CLUSTER_W-1:0] first_q;
	logic [fcca_pkg::LINK_W-1:0]    link_q;

	logic                        ram_we;
	logic [fcca_pkg::IDX_W-1:0]  ram_waddr;
	logic [fcca_pkg::LINK_W-1:0] ram_wdata;
	logic [fcca_pkg::IDX_W-1:0]  ram_raddr;
	logic [fcca_pkg::LINK_W-1:0] ram_rdata;

	logic                        in_range;
	logic [fcca_pkg::IDX_W-1:0]  in_addr;
	logic [fcca_pkg::SUM_W-1:0]  need_sum;
	logic [fcca_pkg::NEED_W-1:0] need_raw;
	logic                        rd_free;
	logic                        rd_link_ok;
	logic                        scan_hit;
	logic                        last_hit;
	logic                        short_space;
	logic                        resp_load;
	logic                        accept;

	assign in_range = 32'(cluster_index) < fcca_pkg::TABLE_ENTRIES;
	assign in_addr  = fcca_pkg::IDX_W'(32'(cluster_index));
	// ceil(size / cluster) as add-and-shift
	assign need_sum = fcca_pkg::SUM_W'(byte_size) +
		fcca_pkg::SUM_W'(fcca_pkg::CLUSTER_BYTES - 1);
	assign need_raw = need_sum[fcca_pkg::SIZE_W:fcca_pkg::CLUSTER_SHIFT];

	assign rd_free    = ram_rdata == fcca_pkg::LINK_FREE;
	assign rd_link_ok = !rd_free && ram_rdata != fcca_pkg::LINK_END &&
		32'(ram_rdata) < fcca_pkg::TABLE_ENTRIES;
	assign scan_hit    = pend_s1 && rd_free;
	assign last_hit    = scan_hit && (taken_q + fcca_pkg::NEED_W'(1) == need_q);
	assign short_space = 32'(free_cnt_q) < 32'(need_q);
	assign resp_load   = state_q == fcca_pkg::ST_RESP && (!out_valid_q || !out_stall);
	assign accept      = in_valid && !in_stall;

	assign in_stall      = state_q != fcca_pkg::ST_IDLE;
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign head_cluster  = first_q;
	assign link_value    = link_q;

	fcca_ram #(
		.WIDTH(fcca_pkg::LINK_W),
		.DEPTH(fcca_pkg::TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcca_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = fcca_pkg::LINK_FREE;
		ram_raddr = addr_q;
		case (state_q)
			fcca_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				if (addr_q == fcca_pkg::LAST_ADDR) begin
					state_d = fcca_pkg::ST_IDLE;
				end
			end
			fcca_pkg::ST_IDLE: begin
				// read issued speculatively at the beat's index
				ram_raddr = in_addr;
				if (in_valid) begin
					case (fcca_pkg::op_t'(operation))
						fcca_pkg::OP_ALLOC: state_d = fcca_pkg::ST_ALLOC_CHK;
						fcca_pkg::OP_FREE: begin
							state_d = (in_range && cluster_index != '0) ?
								fcca_pkg::ST_FREE_WR : fcca_pkg::ST_RESP;
						end
						fcca_pkg::OP_READ: begin
							state_d = in_range ? fcca_pkg::ST_READ_WAIT : fcca_pkg::ST_RESP;
						end
						fcca_pkg::OP_LOAD: begin
							state_d = in_range ? fcca_pkg::ST_LOAD_WR : fcca_pkg::ST_RESP;
						end
						default: state_d = fcca_pkg::ST_RESP;
					endcase
				end
			end
			fcca_pkg::ST_ALLOC_CHK: begin
				state_d = short_space ? fcca_pkg::ST_RESP : fcca_pkg::ST_ALLOC_SCAN;
			end
			fcca_pkg::ST_ALLOC_SCAN: begin
				// link the previous member to this hit; the tail gets its end mark later
				if (scan_hit && taken_q != '0) begin
					ram_we    = 1'b1;
					ram_waddr = prev_q;
					ram_wdata = fcca_pkg::LINK_W'(hit_s1);
				end
				if (last_hit) begin
					state_d = fcca_pkg::ST_ALLOC_END;
				end
			end
			fcca_pkg::ST_ALLOC_END: begin
				ram_we    = 1'b1;
				ram_waddr = prev_q;
				ram_wdata = fcca_pkg::LINK_END;
				state_d   = fcca_pkg::ST_RESP;
			end
			fcca_pkg::ST_FREE_RD: state_d = fcca_pkg::ST_FREE_WR;
			fcca_pkg::ST_FREE_WR: begin
				ram_we  = 1'b1;
				state_d = rd_link_ok ? fcca_pkg::ST_FREE_RD : fcca_pkg::ST_RESP;
			end
			fcca_pkg::ST_READ_WAIT: state_d = fcca_pkg::ST_RESP;
			fcca_pkg::ST_LOAD_WR: begin
				ram_we    = 1'b1;
				ram_wdata = val_q;
				state_d   = fcca_pkg::ST_RESP;
			end
			fcca_pkg::ST_RESP: begin
				if (!out_valid_q || !out_stall) begin
					state_d = fcca_pkg::ST_IDLE;
				end
			end
			default: state_d = fcca_pkg::ST_IDLE;
		endcase
	end

	// control: address sequencer, free count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			pend_s1     <= 1'b0;
			free_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				fcca_pkg::ST_CLEAR: begin
					addr_q <= addr_q + fcca_pkg::IDX_W'(1);
					if (addr_q == fcca_pkg::LAST_ADDR) begin
						free_cnt_q <= fcca_pkg::CNT_W'(fcca_pkg::TABLE_ENTRIES - 1);
					end
				end
				fcca_pkg::ST_IDLE: begin
					pend_s1 <= 1'b0;
					if (in_valid && fcca_pkg::op_t'(operation) == fcca_pkg::OP_ALLOC) begin
						addr_q <= fcca_pkg::IDX_W'(1);
					end else begin
						addr_q <= in_addr;
					end
				end
				fcca_pkg::ST_ALLOC_SCAN: begin
					addr_q  <= addr_q + fcca_pkg::IDX_W'(1);
					pend_s1 <= 1'b1;
					if (last_hit) begin
						free_cnt_q <= free_cnt_q - fcca_pkg::CNT_W'(need_q);
					end
				end
				fcca_pkg::ST_FREE_WR: begin
					addr_q <= ram_rdata[fcca_pkg::IDX_W-1:0];
					if (!rd_free) begin
						free_cnt_q <= free_cnt_q + fcca_pkg::CNT_W'(1);
					end
				end
				fcca_pkg::ST_LOAD_WR: begin
					// entry zero is outside the free pool
					if (addr_q != '0) begin
						if (rd_free && val_q != fcca_pkg::LINK_FREE) begin
							free_cnt_q <= free_cnt_q - fcca_pkg::CNT_W'(1);
						end else if (!rd_free && val_q == fcca_pkg::LINK_FREE) begin
							free_cnt_q <= free_cnt_q + fcca_pkg::CNT_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (state_q)
			fcca_pkg::ST_IDLE: begin
				need_q       <= (need_raw == '0) ? fcca_pkg::NEED_W'(1) : need_raw;
				val_q        <= entry_value;
				taken_q      <= '0;
				res_status_q <= 1'b0;
				res_first_q  <= '0;
				res_link_q   <= '0;
			end
			fcca_pkg::ST_ALLOC_CHK: begin
				if (short_space) begin
					res_status_q <= 1'b1;
				end
			end
			fcca_pkg::ST_ALLOC_SCAN: begin
				hit_s1 <= addr_q;
				if (scan_hit) begin
					taken_q <= taken_q + fcca_pkg::NEED_W'(1);
					prev_q  <= hit_s1;
					if (taken_q == '0) begin
						res_first_q <= fcca_pkg::CLUSTER_W'(hit_s1);
					end
				end
			end
			fcca_pkg::ST_READ_WAIT: res_link_q <= ram_rdata;
			default: begin
			end
		endcase
		if (resp_load) begin
			status_q <= res_status_q;
			first_q  <= res_first_q;
			link_q   <= res_link_q;
		end
	end

	a_alloc_skips_entry0: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fcca_pkg::ST_ALLOC_SCAN && ram_we) |-> ram_waddr != '0)
		else $error("allocate wrote entry zero");

	a_alloc_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fcca_pkg::ST_ALLOC_SCAN |-> 32'(free_cnt_q) >= 32'(need_q))
		else $error("scan started without enough free entries");

	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fcca_pkg::ST_ALLOC_SCAN |-> taken_q < need_q)
		else $error("chain longer than requested");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("second beat taken while busy");

	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == fcca_pkg::ST_RESP)
		else $error("result raised outside response state");

endmodule
